/* src/keyframe_linear_interpolator_core_macros.svh */
// Assertion macros for the keyframe interpolator core.
// Expects clk and rst in the scope of each use; no other dependencies.
`ifndef KEYFRAME_LINEAR_INTERPOLATOR_CORE_MACROS_SVH
`define KEYFRAME_LINEAR_INTERPOLATOR_CORE_MACROS_SVH

// Same-cycle implication
`define KLI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define KLI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/kli_pkg.sv */
// Shared types and constants of the keyframe interpolator core.
// No dependencies; imported by every module of the block.
package kli_pkg;

  localparam int TIME_W    = 32;
  localparam int COORD_W   = 32;
  localparam int COORD_N   = 3;
  localparam int KEY_W     = TIME_W + COORD_N * COORD_W;
  localparam int RES_W     = COORD_N * COORD_W;
  localparam int RATIO_W   = 17;
  localparam int DIV_STEPS = 17;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH_B,
    S_FETCH_A,
    S_DIV_START,
    S_DIV,
    S_BLEND,
    S_OUT
  } state_t;

  // key_time in the lowest bits, same order as the input beat
  typedef struct packed {
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
    logic [TIME_W-1:0]  key_time;
  } key_t;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] offs;
    logic [TIME_W-1:0] span;
  } div_req_t;

endpackage

/* src/kli_keymem.sv */
// Keyframe store: one write port, one read port, registered read data.
// Depends on kli_pkg for the key record type.
module kli_keymem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic           clk,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  kli_pkg::key_t  wr_data,
  input  logic [AW-1:0]  rd_addr,
  output kli_pkg::key_t  rd_data
);
  import kli_pkg::*;

  key_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* src/kli_div.sv */
// Restoring divider for the blend ratio: floor(offs * 2^16 / span), one bit a cycle.
// Requires offs <= span and span > 0. Depends on kli_pkg.
module kli_div (
  input  logic                         clk,
  input  logic                         rst,
  input  kli_pkg::div_req_t            req,
  output logic                         done,
  output logic [kli_pkg::RATIO_W-1:0]  quot
);
  import kli_pkg::*;

  localparam int STEP_W = $clog2(DIV_STEPS);

  logic [TIME_W:0]   rem;
  logic [TIME_W-1:0] span;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic              fits;
  logic [TIME_W:0]   rem_sub;

  always_comb begin
    fits    = rem >= {1'b0, span};
    rem_sub = fits ? (rem - {1'b0, span}) : rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
        rem  <= {1'b0, req.offs};
        span <= req.span;
        quot <= '0;
      end else if (busy) begin
        quot <= {quot[RATIO_W-2:0], fits};
        rem  <= {rem_sub[TIME_W-1:0], 1'b0};
        step <= step + STEP_W'(1);
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* src/kli_blend.sv */
// Two-stage blend of one coordinate: a + ratio*(b-a) in Q16, rounded and saturated.
// Depends on kli_pkg for widths.
module kli_blend (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic signed [kli_pkg::COORD_W-1:0] a,
  input  logic signed [kli_pkg::COORD_W-1:0] b,
  input  logic [kli_pkg::RATIO_W-1:0]        ratio,
  output logic                               out_valid,
  output logic signed [kli_pkg::COORD_W-1:0] result
);
  import kli_pkg::*;

  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = DIFF_W + RATIO_W + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam int RND_W  = SUM_W - 16;

  logic signed [DIFF_W-1:0]  diff;
  logic signed [PROD_W-1:0]  prod_next;
  logic signed [PROD_W-1:0]  prod;
  logic signed [COORD_W-1:0] a1;
  logic                      v1;
  logic signed [SUM_W-1:0]   sum;
  logic signed [RND_W-1:0]   rnd;
  logic signed [COORD_W-1:0] sat;

  always_comb begin
    diff      = {b[COORD_W-1], b} - {a[COORD_W-1], a};
    prod_next = diff * $signed({1'b0, ratio});
    // bias by one half before the floor shift
    sum = $signed({{(SUM_W-COORD_W-16){a1[COORD_W-1]}}, a1, 16'b0})
        + $signed({prod[PROD_W-1], prod})
        + $signed(SUM_W'(32768));
    rnd = sum[SUM_W-1:16];
    if (rnd > $signed({{(RND_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}})) begin
      sat = {1'b0, {(COORD_W-1){1'b1}}};
    end else if (rnd < $signed({{(RND_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}})) begin
      sat = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      sat = rnd[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      out_valid <= v1;
      if (in_valid) begin
        prod <= prod_next;
        a1   <= a;
      end
      if (v1) begin
        result <= sat;
      end
    end
  end

endmodule

/* src/keyframe_linear_interpolator_core.sv */
// Keyframe interpolator top level: control sequencer, keyframe store, ratio divider, blend.
// Depends on kli_pkg, kli_keymem, kli_div, kli_blend and the assertion macro header.
//
//  channel | dir | tdata                              | tuser
//  s_      | in  | time_value, key_x, key_y, key_z    | operation
//  m_      | out | out_x, out_y, out_z                | status, no_key_before
//
// Clear and append pass through accept and result load. A query scans the n stored keyframes
// (reads and compares), fetches the two bracketing keys, starts and runs the bit-serial
// divider, then runs the shared blend over x, y, z before the result load.
// The divider is skipped when the offset or the span is zero, since the ratio is then zero.
// One item is in work at a time. rst is synchronous and empties the table at once. A held
// result does not stop the next beat from being accepted; only the final load waits on m_tready.
`include "keyframe_linear_interpolator_core_macros.svh"

module keyframe_linear_interpolator_core #(
  parameter int MAX_KEYFRAMES = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // [31:0] time_value, [63:32] key_x, [95:64] key_y, [127:96] key_z
  input  logic [kli_pkg::KEY_W-1:0]   s_tdata,
  // [1:0] operation
  input  logic [1:0]                  s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // [31:0] out_x, [63:32] out_y, [95:64] out_z
  output logic [kli_pkg::RES_W-1:0]   m_tdata,
  // [0] status, [1] no_key_before
  output logic [1:0]                  m_tuser
);
  import kli_pkg::*;

  localparam int AW = (MAX_KEYFRAMES > 1) ? $clog2(MAX_KEYFRAMES) : 1;
  localparam int CW = $clog2(MAX_KEYFRAMES + 1);

  state_t state, state_next;

  logic [CW-1:0]      entry_count;
  logic [CW-1:0]      issue_idx;
  logic               issue_fire;
  logic               chk_vld;
  logic [AW-1:0]      chk_idx;
  logic [TIME_W-1:0]  q_time;
  logic [TIME_W-1:0]  bt;
  logic [TIME_W-1:0]  at;
  logic [AW-1:0]      bi;
  logic [AW-1:0]      ai;
  logic               have_b;
  logic               have_a;
  logic               st_query;
  logic               st_status;
  logic [COORD_W-1:0] b_pos [COORD_N];
  logic [COORD_W-1:0] a_pos [COORD_N];
  logic [COORD_W-1:0] res   [COORD_N];
  logic [RATIO_W-1:0] ratio;
  logic [1:0]         iss_cnt;
  logic [1:0]         iss_sel;
  logic [1:0]         cap_cnt;

  logic               accept;
  logic               out_load;
  op_t                op;
  key_t               in_key;
  key_t               rd_key;
  logic               mem_wr;
  logic [AW-1:0]      mem_rd_addr;
  logic [TIME_W-1:0]  kt;
  logic [TIME_W-1:0]  bt_eff;
  logic [TIME_W-1:0]  at_eff;
  logic [TIME_W-1:0]  offs;
  logic [TIME_W-1:0]  span;
  logic               div_go;
  div_req_t           div_req;
  logic               div_done;
  logic [RATIO_W-1:0] div_quot;
  logic               blend_in;
  logic               blend_vld;
  logic [COORD_W-1:0] blend_res;

  assign op     = op_t'(s_tuser);
  assign in_key = key_t'(s_tdata);
  assign accept = s_tvalid && s_tready;
  assign kt     = rd_key.key_time;

  always_comb begin
    bt_eff = have_b ? bt : q_time;
    at_eff = have_a ? at : bt_eff;
    offs   = q_time - bt_eff;
    span   = at_eff - bt_eff;
    // ratio stays zero without a positive offset and a positive span
    div_go = (offs != '0) && (span != '0);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (s_tvalid) state_next = (op == OP_QUERY) ? S_SCAN : S_OUT;
      S_SCAN:      if (issue_idx == entry_count && !chk_vld) state_next = S_FETCH_B;
      S_FETCH_B:   state_next = S_FETCH_A;
      S_FETCH_A:   state_next = S_DIV_START;
      S_DIV_START: state_next = div_go ? S_DIV : S_BLEND;
      S_DIV:       if (div_done) state_next = S_BLEND;
      S_BLEND:     if (blend_vld && cap_cnt == 2'd2) state_next = S_OUT;
      S_OUT:       if (!m_tvalid || m_tready) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready      = 1'b0;
    issue_fire    = 1'b0;
    mem_rd_addr   = ai;
    div_req.start = 1'b0;
    div_req.offs  = offs;
    div_req.span  = span;
    blend_in      = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      S_IDLE:      s_tready = 1'b1;
      S_SCAN: begin
        issue_fire  = issue_idx != entry_count;
        mem_rd_addr = issue_idx[AW-1:0];
      end
      S_FETCH_B:   mem_rd_addr = bi;
      S_FETCH_A:   mem_rd_addr = ai;
      S_DIV_START: div_req.start = div_go;
      S_DIV:       ;
      S_BLEND:     blend_in = iss_cnt != 2'd3;
      S_OUT:       out_load = !m_tvalid || m_tready;
      default:     ;
    endcase
  end

  assign mem_wr  = accept && op == OP_APPEND && entry_count < CW'(MAX_KEYFRAMES);
  assign iss_sel = (iss_cnt < 2'd3) ? iss_cnt : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      chk_vld     <= 1'b0;
    end else begin
      state   <= state_next;
      chk_vld <= issue_fire;
      if (accept) begin
        case (op)
          OP_CLEAR:  entry_count <= '0;
          OP_APPEND: if (mem_wr) entry_count <= entry_count + CW'(1);
          default:   ;
        endcase
      end
    end
  end

  // item capture and scan bookkeeping
  always_ff @(posedge clk) begin
    if (accept) begin
      q_time    <= in_key.key_time;
      st_query  <= op == OP_QUERY;
      st_status <= op == OP_APPEND && entry_count >= CW'(MAX_KEYFRAMES);
      issue_idx <= '0;
      bt        <= '0;
      at        <= '1;
      have_b    <= 1'b0;
      have_a    <= 1'b0;
    end else begin
      if (issue_fire) begin
        issue_idx <= issue_idx + CW'(1);
      end
      chk_idx <= issue_idx[AW-1:0];
      // later entries win ties
      if (chk_vld) begin
        if (kt <= q_time && kt >= bt) begin
          bt     <= kt;
          bi     <= chk_idx;
          have_b <= 1'b1;
        end
        if (kt >= q_time && kt <= at) begin
          at     <= kt;
          ai     <= chk_idx;
          have_a <= 1'b1;
        end
      end
    end
  end

  // bracketing keys, ratio and blend results
  always_ff @(posedge clk) begin
    if (state == S_FETCH_A) begin
      b_pos[0] <= have_b ? rd_key.x : '0;
      b_pos[1] <= have_b ? rd_key.y : '0;
      b_pos[2] <= have_b ? rd_key.z : '0;
    end
    if (state == S_DIV_START) begin
      a_pos[0] <= have_a ? rd_key.x : b_pos[0];
      a_pos[1] <= have_a ? rd_key.y : b_pos[1];
      a_pos[2] <= have_a ? rd_key.z : b_pos[2];
      ratio    <= '0;
      iss_cnt  <= '0;
      cap_cnt  <= '0;
    end
    if (div_done) begin
      ratio <= div_quot;
    end
    if (blend_in) begin
      iss_cnt <= iss_cnt + 2'd1;
    end
    if (blend_vld) begin
      res[cap_cnt] <= blend_res;
      cap_cnt      <= cap_cnt + 2'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
      m_tdata  <= st_query ? {res[2], res[1], res[0]} : '0;
      m_tuser  <= {st_query & ~have_b, st_status};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  kli_keymem #(
    .DEPTH (MAX_KEYFRAMES),
    .AW    (AW)
  ) u_keymem (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (entry_count[AW-1:0]),
    .wr_data (in_key),
    .rd_addr (mem_rd_addr),
    .rd_data (rd_key)
  );

  kli_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (div_quot)
  );

  kli_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (blend_in),
    .a         ($signed(b_pos[iss_sel])),
    .b         ($signed(a_pos[iss_sel])),
    .ratio     (ratio),
    .out_valid (blend_vld),
    .result    (blend_res)
  );

  `KLI_ASSERT_NOW(a_count_bound, 1'b1, entry_count <= CW'(MAX_KEYFRAMES), "entry count past depth")
  `KLI_ASSERT_NOW(a_div_owner, div_done, state == S_DIV, "divider done outside divide state")
  `KLI_ASSERT_NOW(a_blend_owner, blend_vld, state == S_BLEND, "blend result outside blend state")
  `KLI_ASSERT_NEXT(a_full_drop, accept && op == OP_APPEND && entry_count == CW'(MAX_KEYFRAMES), st_status && entry_count == CW'(MAX_KEYFRAMES), "full-table append not dropped")

endmodule

/* dv/tb_top.sv */
// Self-checking bench for keyframe_linear_interpolator_core: clear, append and query beats
// are scored against an in-bench interpolation predictor. Depends on kli_pkg and the core.
module tb_top;
  import kli_pkg::*;

  localparam int MAX_KEYS = 64;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [31:0] T_MAX = 32'hFFFF_FFFF;
  localparam logic [31:0] C_MIN = 32'h8000_0000;
  localparam logic [31:0] C_MAX = 32'h7FFF_FFFF;
  localparam longint Q_ONE = 65536;
  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;
  localparam int STALL_LIMIT = 4000;
  localparam int SINK_HOLD_CYCLES = 600;
  localparam int DRAIN_CYCLES = 100;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic                             status;
    logic                             no_key_before;
    logic [COORD_N-1:0][COORD_W-1:0]  pos;
  } interp_beat_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [KEY_W-1:0]     s_tdata = '0;
  logic [1:0]           s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [RES_W-1:0]     m_tdata;
  logic [1:0]           m_tuser;

  // predictor copy of the keyframe store
  logic [TIME_W-1:0]                key_times_q [MAX_KEYS];
  logic [COORD_N-1:0][COORD_W-1:0]  key_pos_q [MAX_KEYS];
  int                               key_count = 0;

  interp_beat_t expected_beats [$];
  interp_beat_t head_beat;
  int           mismatches = 0;
  int           items_sent = 0;
  int           stall_cycles = 0;
  int           src_gap_pct = 25;
  logic         idle_on = 1'b1;
  logic         sink_hold_req = 1'b0;

  always #1 clk = ~clk;

  keyframe_linear_interpolator_core #(
    .MAX_KEYFRAMES(MAX_KEYS)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  // Advance the store copy by one beat and return the result it should produce.
  function automatic interp_beat_t interp_step(logic [1:0] op, logic [31:0] t,
                                               logic [COORD_N-1:0][COORD_W-1:0] pos);
    interp_beat_t r;
    logic         have_b, have_a;
    int           bi, ai;
    logic [31:0]  bt, at, kt;
    longint       span, offs, ratio, bv, av, sum, mix;
    r = '0;
    case (op)
      OP_CLEAR: key_count = 0;
      OP_APPEND: begin
        if (key_count >= MAX_KEYS) begin
          r.status = 1'b1;
        end else begin
          key_times_q[key_count] = t;
          key_pos_q[key_count] = pos;
          key_count++;
        end
      end
      OP_QUERY: begin
        have_b = 1'b0;
        have_a = 1'b0;
        bi = 0;
        ai = 0;
        bt = '0;
        at = '1;
        // later entries win ties on both sides
        for (int i = 0; i < key_count; i++) begin
          kt = key_times_q[i];
          if (kt <= t && kt >= bt) begin
            bt = kt;
            bi = i;
            have_b = 1'b1;
          end
          if (kt >= t && kt <= at) begin
            at = kt;
            ai = i;
            have_a = 1'b1;
          end
        end
        if (!have_b) bt = t;
        if (!have_a) at = bt;
        span = $signed({32'd0, at}) - $signed({32'd0, bt});
        offs = $signed({32'd0, t}) - $signed({32'd0, bt});
        ratio = 0;
        if (span > 0 && offs > 0) begin
          ratio = (offs <<< 16) / span;
          if (ratio > Q_ONE) ratio = Q_ONE;
        end
        for (int c = 0; c < COORD_N; c++) begin
          bv = 0;
          if (have_b) bv = $signed(key_pos_q[bi][c]);
          av = bv;
          if (have_a) av = $signed(key_pos_q[ai][c]);
          sum = (Q_ONE - ratio) * bv + ratio * av;
          // round half up: floor of (sum + 0.5)
          mix = (sum + 32768) >>> 16;
          if (mix > COORD_MAX) mix = COORD_MAX;
          if (mix < COORD_MIN) mix = COORD_MIN;
          r.pos[c] = mix[31:0];
        end
        r.no_key_before = !have_b;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return C_MIN;
      1: return C_MAX;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [COORD_N-1:0][COORD_W-1:0] rand_pos();
    return {pick_coord(), pick_coord(), pick_coord()};
  endfunction

  // Query times that land on, near and between stored keys, plus the ends of the range.
  function automatic logic [31:0] pick_query_time();
    logic [31:0] ka, kb;
    if (key_count == 0) return $urandom;
    ka = key_times_q[$urandom_range(0, key_count - 1)];
    kb = key_times_q[$urandom_range(0, key_count - 1)];
    case ($urandom_range(0, 9))
      0, 1, 2: return ka;
      3, 4:    return ka + $urandom_range(0, 32'h2_0000) - 32'h1_0000;
      5:       return (ka >> 1) + (kb >> 1);
      6, 7:    return $urandom;
      8:       return '0;
      default: return T_MAX;
    endcase
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [31:0] t,
                           input logic [COORD_N-1:0][COORD_W-1:0] pos);
    if (idle_on && $urandom_range(0, 99) < src_gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {pos, t};
    s_tuser <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_beats = {expected_beats, interp_step(op, t, pos)};
    items_sent++;
  endtask

  // Random clear / fill / query sequences until n_items more beats have gone in.
  task automatic run_sequences(input int n_items);
    int          stop_at, n_keys, n_q;
    logic [31:0] base, step, t;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      src_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
      if ($urandom_range(0, 5) != 0) send_item(OP_CLEAR, $urandom, rand_pos());
      case ($urandom_range(0, 9))
        7, 8:    n_keys = $urandom_range(9, 32);
        9:       n_keys = $urandom_range(33, 70);
        default: n_keys = $urandom_range(1, 8);
      endcase
      base = $urandom;
      step = $urandom_range(1, 32'h2_0000);
      for (int k = 0; k < n_keys; k++) begin
        case ($urandom_range(0, 5))
          0: t = $urandom;
          1: t = (key_count > 0) ? key_times_q[$urandom_range(0, key_count - 1)] : base;
          2: t = base - k * step;
          default: t = base + k * step + $urandom_range(0, 3);
        endcase
        send_item(OP_APPEND, t, rand_pos());
      end
      n_q = $urandom_range(2, 12);
      for (int q = 0; q < n_q; q++) begin
        case ($urandom_range(0, 19))
          0: send_item(OP_UNUSED, $urandom, rand_pos());
          1: send_item(OP_APPEND, $urandom, rand_pos());
          default: send_item(OP_QUERY, pick_query_time(), rand_pos());
        endcase
      end
    end
  endtask

  task automatic test_directed();
    send_item(OP_QUERY, '0, rand_pos());
    send_item(OP_QUERY, T_MAX, rand_pos());
    send_item(OP_CLEAR, '0, '0);
    send_item(OP_APPEND, 32'h0001_0000, {32'd0, C_MAX, C_MIN});
    send_item(OP_APPEND, 32'h0003_0000, {32'hFFFF_FFFF, C_MIN, C_MAX});
    send_item(OP_QUERY, 32'h0001_0000, '0);
    send_item(OP_QUERY, 32'h0002_0000, '0);
    send_item(OP_QUERY, 32'h0001_8000, '0);
    // before the first key: no before key, zero position
    send_item(OP_QUERY, '0, '0);
    // past the last key: after key falls back to the before key
    send_item(OP_QUERY, T_MAX, '0);
    // same time as an existing key: the later entry must win
    send_item(OP_APPEND, 32'h0003_0000, {32'd3, 32'd2, 32'd1});
    send_item(OP_QUERY, 32'h0003_0000, '0);
    send_item(OP_QUERY, 32'h0002_8000, '0);
    send_item(OP_APPEND, '0, {C_MIN, C_MIN, C_MAX});
    send_item(OP_APPEND, T_MAX, {C_MAX, C_MAX, C_MIN});
    send_item(OP_QUERY, '0, '1);
    send_item(OP_QUERY, T_MAX, '1);
    send_item(OP_QUERY, 32'h8000_0000, '1);
    send_item(OP_UNUSED, T_MAX, '1);
    send_item(OP_CLEAR, T_MAX, '1);
    send_item(OP_QUERY, 32'h0002_0000, '0);
    send_item(OP_APPEND, 32'h0002_0000, {32'd7, 32'd6, 32'd5});
    send_item(OP_QUERY, 32'h0002_0001, '0);
  endtask

  task automatic test_full_table();
    send_item(OP_CLEAR, $urandom, rand_pos());
    for (int k = 0; k < MAX_KEYS; k++) send_item(OP_APPEND, $urandom, rand_pos());
    // table full: these must be dropped with status set
    for (int k = 0; k < 3; k++) send_item(OP_APPEND, $urandom, rand_pos());
    for (int q = 0; q < 6; q++) send_item(OP_QUERY, pick_query_time(), rand_pos());
    send_item(OP_UNUSED, $urandom, rand_pos());
  endtask

  task automatic test_backpressure();
    sink_hold_req = 1'b1;
    send_item(OP_CLEAR, $urandom, rand_pos());
    for (int k = 0; k < 12; k++) send_item(OP_APPEND, $urandom, rand_pos());
    for (int q = 0; q < 20; q++) send_item(OP_QUERY, pick_query_time(), rand_pos());
  endtask

  task automatic test_random_sequences();
    run_sequences(1000);
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    run_sequences(100);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch on %s: expected %h, got %h", name, want, got);
    end
  endtask

  // Receiver: random stalls, calm stretches, and one long hold when requested.
  initial begin
    forever begin
      if (sink_hold_req) begin
        m_tready <= 1'b0;
        for (int i = 0; i < SINK_HOLD_CYCLES; i++) @(posedge clk);
        sink_hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 31) == 0) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(30, 150)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result beat with nothing pending: tdata %h tuser %h", m_tdata, m_tuser);
      end else begin
        head_beat = expected_beats.pop_front();
        check_field("status", head_beat.status, m_tuser[0]);
        check_field("no_key_before", head_beat.no_key_before, m_tuser[1]);
        check_field("out_x", head_beat.pos[0], m_tdata[31:0]);
        check_field("out_y", head_beat.pos[1], m_tdata[63:32]);
        check_field("out_z", head_beat.pos[2], m_tdata[95:64]);
      end
    end
  end

  // Watchdog: end the run when no beat moves on either side for too long.
  initial begin
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_table();
    test_backpressure();
    test_random_sequences();
    test_steady_stream();
    s_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
